/* src/mbps_pkg.sv */
// Shared types and constants for the masked byte pattern scanner.
`default_nettype none

package mbps_pkg;

  localparam int AddrW    = 48;
  localparam int ByteW    = 8;
  localparam int PatBytes = 16;
  localparam int PatW     = PatBytes * ByteW;
  localparam int LenW     = 5;
  localparam int CountW   = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PATTERN_LOW    = 3'd0,
    CFG_PATTERN_HIGH   = 3'd1,
    CFG_CARE_MASK      = 3'd2,
    CFG_PATTERN_LENGTH = 3'd3,
    CFG_RESULT_LIMIT   = 3'd4
  } mbps_cfg_idx_t;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic [AddrW-1:0] byte_address;
    logic             region_start;
    logic             new_scan;
  } mbps_in_t;

  typedef struct packed {
    logic [AddrW-1:0]  match_address;
    logic [CountW-1:0] match_number;
    logic              limit_reached;
  } mbps_out_t;

  typedef struct packed {
    logic             new_scan;
    logic             hit;
    logic [AddrW-1:0] start_address;
  } mbps_cmd_t;

endpackage

`default_nettype wire

/* src/mbps_front.sv */
// Front end: sliding byte window, masked compare and start-address computation.
`default_nettype none

module mbps_front #(
  parameter int PAT_CAP = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             accept,
  input  wire mbps_pkg::mbps_in_t               in_data,
  input  wire logic [mbps_pkg::PatW-1:0]        pattern,
  input  wire logic [mbps_pkg::PatBytes-1:0]    care_mask,
  input  wire logic [mbps_pkg::LenW-1:0]        pattern_length,
  output logic                                  push,
  output mbps_pkg::mbps_cmd_t                   push_cmd
);

  logic [mbps_pkg::ByteW-1:0] window_r [PAT_CAP];
  logic [mbps_pkg::ByteW-1:0] window_nxt [PAT_CAP];
  logic [mbps_pkg::LenW-1:0]  fill_r;
  logic [mbps_pkg::LenW-1:0]  fill_nxt;
  logic [mbps_pkg::LenW-1:0]  fill_base;
  logic [mbps_pkg::LenW-1:0]  len_used;
  logic                       mismatch;
  logic                       hit;

  always_comb begin
    if (pattern_length == '0) begin
      len_used = mbps_pkg::LenW'(1);
    end else if (pattern_length > mbps_pkg::LenW'(PAT_CAP)) begin
      len_used = mbps_pkg::LenW'(PAT_CAP);
    end else begin
      len_used = pattern_length;
    end
  end

  always_comb begin
    window_nxt[0] = in_data.data_byte;
    for (int j = 1; j < PAT_CAP; j++) begin
      window_nxt[j] = window_r[j-1];
    end
  end

  always_comb begin
    fill_base = in_data.region_start ? '0 : fill_r;
    if (fill_base < mbps_pkg::LenW'(PAT_CAP)) begin
      fill_nxt = fill_base + mbps_pkg::LenW'(1);
    end else begin
      fill_nxt = fill_base;
    end
  end

  // pattern byte i lines up with window byte j when i + j == len - 1
  always_comb begin
    mismatch = 1'b0;
    for (int i = 0; i < PAT_CAP; i++) begin
      for (int j = 0; j < PAT_CAP; j++) begin
        if ((i + j == int'(len_used) - 1) && care_mask[i] &&
            (window_nxt[j] != pattern[i*mbps_pkg::ByteW +: mbps_pkg::ByteW])) begin
          mismatch = 1'b1;
        end
      end
    end
  end

  assign hit = (fill_nxt >= len_used) && !mismatch;

  always_comb begin
    push                   = accept && (hit || in_data.new_scan);
    push_cmd.new_scan      = in_data.new_scan;
    push_cmd.hit           = hit;
    push_cmd.start_address = in_data.byte_address
                           - mbps_pkg::AddrW'(len_used - mbps_pkg::LenW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      for (int j = 0; j < PAT_CAP; j++) begin
        window_r[j] <= '0;
      end
    end else if (accept) begin
      fill_r <= fill_nxt;
      for (int j = 0; j < PAT_CAP; j++) begin
        window_r[j] <= window_nxt[j];
      end
    end
  end

  fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= mbps_pkg::LenW'(PAT_CAP))
    else $error("window fill beyond window size");

  fill_restart: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.region_start |=> fill_r == mbps_pkg::LenW'(1))
    else $error("region start did not restart window fill");

  short_fill_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_cmd.hit |-> fill_nxt >= len_used)
    else $error("hit reported on a partly filled window");

endmodule

`default_nettype wire

/* src/mbps_fifo.sv */
// Short queue of classified items between front and back ends.
`default_nettype none

module mbps_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire mbps_pkg::mbps_cmd_t push_cmd,
  input  wire logic                pop,
  output mbps_pkg::mbps_cmd_t      pop_cmd,
  output logic                     full,
  output logic                     empty
);

  localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  mbps_pkg::mbps_cmd_t entry_r [DEPTH];
  logic [IdxW-1:0]     wr_ptr_r;
  logic [IdxW-1:0]     rd_ptr_r;
  logic [CntW-1:0]     count_r;

  assign full    = (count_r == CntW'(DEPTH));
  assign empty   = (count_r == '0);
  assign pop_cmd = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == IdxW'(DEPTH - 1)) ? '0 : wr_ptr_r + IdxW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == IdxW'(DEPTH - 1)) ? '0 : rd_ptr_r + IdxW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CntW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CntW'(1);
      end
    end
  end

  no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop)
    else $error("queue overflow");

  no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue underflow");

  count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(DEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

/* src/mbps_back.sv */
// Back end: match counting, stop flag and output register.
`default_nettype none

module mbps_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire mbps_pkg::mbps_cmd_t           pop_cmd,
  input  wire logic                          empty,
  input  wire logic [mbps_pkg::CountW-1:0]   result_limit,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output mbps_pkg::mbps_out_t                out_data
);

  logic [mbps_pkg::CountW-1:0] count_r;
  logic [mbps_pkg::CountW-1:0] count_nxt;
  logic                        stopped_r;
  logic                        stopped_nxt;
  logic                        out_valid_r;
  mbps_pkg::mbps_out_t         out_data_r;
  logic [mbps_pkg::CountW-1:0] count_base;
  logic                        stopped_base;
  logic [mbps_pkg::CountW-1:0] count_inc;
  logic [mbps_pkg::CountW-1:0] limit_used;
  logic                        emit;
  logic                        stop_hit;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pop       = !empty && (!out_valid_r || !out_stall);

  always_comb begin
    limit_used   = (result_limit == '0) ? mbps_pkg::CountW'(1) : result_limit;
    count_base   = pop_cmd.new_scan ? '0 : count_r;
    stopped_base = pop_cmd.new_scan ? 1'b0 : stopped_r;
    count_inc    = count_base + mbps_pkg::CountW'(1);
    stop_hit     = (count_inc >= limit_used) || (count_inc == '1);
    emit         = pop_cmd.hit && !stopped_base;
    count_nxt    = emit ? count_inc : count_base;
    stopped_nxt  = emit ? stop_hit : stopped_base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      stopped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (pop) begin
      count_r     <= count_nxt;
      stopped_r   <= stopped_nxt;
      out_valid_r <= emit;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_data_r.match_address <= pop_cmd.start_address;
      out_data_r.match_number  <= count_inc;
      out_data_r.limit_reached <= stop_hit;
    end
  end

  number_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.match_number != '0)
    else $error("result with zero match number");

  limit_stops_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.limit_reached |-> stopped_r)
    else $error("limit flagged but scan not stopped");

  number_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.match_number == count_r)
    else $error("shown match number differs from match count");

endmodule

`default_nettype wire

/* src/masked_byte_pattern_scan_core.sv */
// Top level of the masked byte pattern scanner: configuration registers and wiring.
//
// Takes one memory byte per item and reports each window whose care bytes equal
// the programmed pattern, with its start address, running match number and a
// limit flag; after the limit is reached matches are dropped until an item with
// new_scan. One item is accepted per clock cycle: the window shift and the full
// parallel byte compare are combinational in the front end, a four-entry queue
// carries hits and scan restarts to the counting back end, and a result passes
// through a queue entry and then the back-end output register. The input stalls
// only when the queue is full, which happens only while the output side is stalled.
// The user writes configuration only while the block is idle; it is not enforced.
`default_nettype none

module masked_byte_pattern_scan_core #(
  parameter int PATTERN_MAX = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire mbps_pkg::mbps_in_t                in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output mbps_pkg::mbps_out_t                    out_data,
  input  wire logic                              cfg_we,
  input  wire logic [mbps_pkg::CfgIdxW-1:0]      cfg_index,
  input  wire logic [mbps_pkg::CfgDataW-1:0]     cfg_data
);

  localparam int PatCap = (PATTERN_MAX < mbps_pkg::PatBytes) ? PATTERN_MAX
                                                             : mbps_pkg::PatBytes;

  logic [mbps_pkg::CfgDataW-1:0] pattern_low_r;
  logic [mbps_pkg::CfgDataW-1:0] pattern_high_r;
  logic [mbps_pkg::PatBytes-1:0] care_mask_r;
  logic [mbps_pkg::LenW-1:0]     pattern_length_r;
  logic [mbps_pkg::CountW-1:0]   result_limit_r;

  logic                in_accept;
  logic                push;
  mbps_pkg::mbps_cmd_t push_cmd;
  mbps_pkg::mbps_cmd_t pop_cmd;
  logic                pop;
  logic                full;
  logic                empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_low_r    <= '0;
      pattern_high_r   <= '0;
      care_mask_r      <= '1;
      pattern_length_r <= mbps_pkg::LenW'(mbps_pkg::PatBytes);
      result_limit_r   <= mbps_pkg::CountW'(1);
    end else if (cfg_we) begin
      case (mbps_pkg::mbps_cfg_idx_t'(cfg_index))
        mbps_pkg::CFG_PATTERN_LOW:    pattern_low_r    <= cfg_data;
        mbps_pkg::CFG_PATTERN_HIGH:   pattern_high_r   <= cfg_data;
        mbps_pkg::CFG_CARE_MASK:      care_mask_r      <= cfg_data[mbps_pkg::PatBytes-1:0];
        mbps_pkg::CFG_PATTERN_LENGTH: pattern_length_r <= cfg_data[mbps_pkg::LenW-1:0];
        mbps_pkg::CFG_RESULT_LIMIT:   result_limit_r   <= cfg_data[mbps_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall  = full;
  assign in_accept = in_valid && !in_stall;

  mbps_front #(
    .PAT_CAP (PatCap)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (in_accept),
    .in_data        (in_data),
    .pattern        ({pattern_high_r, pattern_low_r}),
    .care_mask      (care_mask_r),
    .pattern_length (pattern_length_r),
    .push           (push),
    .push_cmd       (push_cmd)
  );

  mbps_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .full     (full),
    .empty    (empty)
  );

  mbps_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .pop_cmd      (pop_cmd),
    .empty        (empty),
    .result_limit (result_limit_r),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

endmodule

`default_nettype wire

/* tb/tb_masked_byte_pattern_scan_core.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the masked byte pattern scan core.
module tb_masked_byte_pattern_scan_core;

  typedef struct packed {
    bit                                is_cfg;
    logic [63:0]                       lo;
    logic [63:0]                       hi;
    logic [15:0]                       care;
    logic [mbps_pkg::LenW-1:0]         len;
    logic [mbps_pkg::CountW-1:0]       lim;
    mbps_pkg::mbps_in_t                item;
    bit                                fixed;
    bit                                fixed_hit;
    mbps_pkg::mbps_out_t               fixed_out;
  } scan_row_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  mbps_pkg::mbps_in_t            in_data = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  mbps_pkg::mbps_out_t           out_data;
  logic                          cfg_we = 1'b0;
  logic [mbps_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [mbps_pkg::CfgDataW-1:0] cfg_data = '0;

  logic [mbps_pkg::PatW-1:0]   pat_bytes = '0;
  logic [15:0]                 care_bits = 16'hFFFF;
  logic [mbps_pkg::LenW-1:0]   len_cfg = 5'd16;
  logic [mbps_pkg::CountW-1:0] limit_cfg = 16'd1;
  logic [mbps_pkg::ByteW-1:0]  win_bytes [mbps_pkg::PatBytes] = '{default: '0};
  int                          win_fill = 0;
  logic [mbps_pkg::CountW-1:0] scan_count = '0;
  bit                          scan_stopped = 1'b0;

  mbps_pkg::mbps_out_t pending_matches [$];
  scan_row_t           script [$];
  bit        calm = 1'b0;
  bit        hold_req = 1'b0;
  int        err_count = 0;
  int        items_sent = 0;
  int        results_checked = 0;
  int        held_cycles = 0;
  int        cfg_loads = 0;

  masked_byte_pattern_scan_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int eff_len();
    int n;
    n = int'(len_cfg);
    if (n < 1) n = 1;
    if (n > mbps_pkg::PatBytes) n = mbps_pkg::PatBytes;
    return n;
  endfunction

  function automatic void predict_scan(input mbps_pkg::mbps_in_t it, output bit hit,
                                       output mbps_pkg::mbps_out_t res);
    int n;
    int lim;
    bit ok;
    n = eff_len();
    lim = (limit_cfg == 0) ? 1 : int'(limit_cfg);
    hit = 1'b0;
    res = '0;
    if (it.new_scan) begin
      scan_count = '0;
      scan_stopped = 1'b0;
    end
    if (it.region_start) win_fill = 0;
    for (int i = mbps_pkg::PatBytes - 1; i > 0; i--) win_bytes[i] = win_bytes[i-1];
    win_bytes[0] = it.data_byte;
    if (win_fill < mbps_pkg::PatBytes) win_fill++;
    if (scan_stopped || win_fill < n) return;
    ok = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (care_bits[i] &&
          win_bytes[n-1-i] != pat_bytes[i*mbps_pkg::ByteW +: mbps_pkg::ByteW]) ok = 1'b0;
    end
    if (!ok) return;
    scan_count = scan_count + 16'd1;
    if (scan_count >= lim || scan_count == 16'hFFFF) scan_stopped = 1'b1;
    hit = 1'b1;
    res.match_address = it.byte_address - mbps_pkg::AddrW'(n - 1);
    res.match_number = scan_count;
    res.limit_reached = scan_stopped;
  endfunction

  task automatic note_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic send_byte(input mbps_pkg::mbps_in_t it, input bit fixed,
                           input bit fixed_hit, input mbps_pkg::mbps_out_t fixed_out);
    int gap;
    bit hit;
    mbps_pkg::mbps_out_t res;
    gap = calm ? 0 : $urandom_range(0, 11);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_scan(it, hit, res);
    if (fixed) begin
      hit = fixed_hit;
      res = fixed_out;
    end
    if (hit) pending_matches = {pending_matches, res};
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_matches.size() != 0) @(negedge clk);
    repeat (24) @(negedge clk);
  endtask

  task automatic load_config(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [15:0] care,
                             input logic [mbps_pkg::LenW-1:0] len,
                             input logic [mbps_pkg::CountW-1:0] lim);
    cfg_we <= 1'b1;
    cfg_index <= mbps_pkg::CFG_PATTERN_LOW;
    cfg_data <= lo;
    @(negedge clk);
    cfg_index <= mbps_pkg::CFG_PATTERN_HIGH;
    cfg_data <= hi;
    @(negedge clk);
    cfg_index <= mbps_pkg::CFG_CARE_MASK;
    cfg_data <= mbps_pkg::CfgDataW'(care);
    @(negedge clk);
    cfg_index <= mbps_pkg::CFG_PATTERN_LENGTH;
    cfg_data <= mbps_pkg::CfgDataW'(len);
    @(negedge clk);
    cfg_index <= mbps_pkg::CFG_RESULT_LIMIT;
    cfg_data <= mbps_pkg::CfgDataW'(lim);
    @(negedge clk);
    cfg_we <= 1'b0;
    pat_bytes = {hi, lo};
    care_bits = care;
    len_cfg = len;
    limit_cfg = lim;
    cfg_loads++;
  endtask

  task automatic add_cfg(input logic [63:0] lo, input logic [63:0] hi,
                         input logic [15:0] care, input logic [mbps_pkg::LenW-1:0] len,
                         input logic [mbps_pkg::CountW-1:0] lim);
    scan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.lo = lo;
    r.hi = hi;
    r.care = care;
    r.len = len;
    r.lim = lim;
    script = {script, r};
  endtask

  task automatic add_byte(input logic [7:0] data, input logic [mbps_pkg::AddrW-1:0] addr,
                          input bit rs, input bit ns, input bit fixed, input bit fhit,
                          input logic [mbps_pkg::AddrW-1:0] faddr, input logic [15:0] fnum,
                          input bit flim);
    scan_row_t r;
    r = '0;
    r.item.data_byte = data;
    r.item.byte_address = addr;
    r.item.region_start = rs;
    r.item.new_scan = ns;
    r.fixed = fixed;
    r.fixed_hit = fhit;
    r.fixed_out.match_address = faddr;
    r.fixed_out.match_number = fnum;
    r.fixed_out.limit_reached = flim;
    script = {script, r};
  endtask

  task automatic run_phase(input int n_items);
    logic [63:0]                 lo;
    logic [63:0]                 hi;
    logic [15:0]                 care;
    logic [mbps_pkg::LenW-1:0]   len;
    logic [mbps_pkg::CountW-1:0] lim;
    logic [mbps_pkg::AddrW-1:0]  addr;
    mbps_pkg::mbps_in_t          it;
    int                          plen;
    int                          burst_pos;
    int                          burst_left;
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: care = 16'h0000;
      1: care = 16'hFFFF;
      default: care = 16'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0: len = 5'd0;
      1: len = mbps_pkg::LenW'($urandom_range(17, 31));
      2: len = 5'd16;
      3: len = 5'd1;
      default: len = mbps_pkg::LenW'($urandom_range(2, 8));
    endcase
    case ($urandom_range(0, 5))
      0: lim = 16'd0;
      1: lim = 16'd1;
      2: lim = 16'hFFFF;
      default: lim = mbps_pkg::CountW'($urandom_range(2, 12));
    endcase
    wait_drained();
    load_config(lo, hi, care, len, lim);
    plen = eff_len();
    burst_left = 0;
    burst_pos = 0;
    addr = mbps_pkg::AddrW'({$urandom, $urandom});
    for (int k = 0; k < n_items; k++) begin
      if (burst_left == 0 && $urandom_range(0, 2) == 0) begin
        burst_left = plen;
        burst_pos = 0;
      end
      if (burst_left > 0) begin
        if (care_bits[burst_pos])
          it.data_byte = pat_bytes[burst_pos*mbps_pkg::ByteW +: mbps_pkg::ByteW];
        else it.data_byte = 8'($urandom);
        if ($urandom_range(0, 9) == 0) it.data_byte = 8'($urandom);
        burst_pos++;
        burst_left--;
      end else if ($urandom_range(0, 3) == 0) begin
        it.data_byte =
          pat_bytes[$urandom_range(0, plen - 1)*mbps_pkg::ByteW +: mbps_pkg::ByteW];
      end else begin
        it.data_byte = 8'($urandom);
      end
      it.region_start = (k == 0) || ($urandom_range(0, 39) == 0);
      it.new_scan = ($urandom_range(0, 19) == 0);
      if (it.region_start) begin
        case ($urandom_range(0, 4))
          0: addr = '0;
          1: addr = '1;
          default: addr = mbps_pkg::AddrW'({$urandom, $urandom});
        endcase
      end else begin
        addr = addr + mbps_pkg::AddrW'(1);
      end
      it.byte_address = addr;
      send_byte(it, 1'b0, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin : check_results
    mbps_pkg::mbps_out_t want;
    if (in_valid && in_stall) held_cycles++;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_matches.size() == 0) begin
        note_mismatch($sformatf("result with nothing pending, address %h",
                                out_data.match_address));
      end else begin
        want = pending_matches.pop_front();
        results_checked++;
        if (out_data.match_address !== want.match_address)
          note_mismatch($sformatf("match_address %h, want %h",
                                  out_data.match_address, want.match_address));
        if (out_data.match_number !== want.match_number)
          note_mismatch($sformatf("match_number %0d, want %0d",
                                  out_data.match_number, want.match_number));
        if (out_data.limit_reached !== want.limit_reached)
          note_mismatch($sformatf("limit_reached %b, want %b",
                                  out_data.limit_reached, want.limit_reached));
      end
    end
  end

  initial begin : result_side
    int w;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (200) @(negedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        w = calm ? 0 : $urandom_range(0, 11);
        if (w > 0) begin
          out_stall <= 1'b1;
          repeat (w) @(negedge clk);
        end
        out_stall <= 1'b0;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    #3_000_000;
    $display("Timeout with %0d results still pending", pending_matches.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    mbps_pkg::mbps_in_t it;
    for (int i = 0; i < 16; i++)
      add_byte(8'h00, 48'h1000 + i, i == 0, i == 0, 1'b1, i == 15, 48'h1000, 16'd1, 1'b1);
    add_byte(8'h00, 48'h1010, 1'b0, 1'b0, 1'b1, 1'b0, '0, 16'd0, 1'b0);
    add_cfg('1, '1, 16'h0000, 5'd0, 16'd0);
    add_byte(8'hFF, '1, 1'b1, 1'b1, 1'b1, 1'b1, '1, 16'd1, 1'b1);
    add_byte(8'h00, '0, 1'b0, 1'b0, 1'b1, 1'b0, '0, 16'd0, 1'b0);
    add_cfg(64'h0000_0000_00CC_33AA, 64'h0, 16'hFFF5, 5'd3, 16'd2);
    add_byte(8'hAA, '1, 1'b1, 1'b1, 1'b0, 1'b0, '0, 16'd0, 1'b0);
    add_byte(8'h5A, 48'h0, 1'b0, 1'b0, 1'b0, 1'b0, '0, 16'd0, 1'b0);
    add_byte(8'hCC, 48'h1, 1'b0, 1'b0, 1'b0, 1'b0, '0, 16'd0, 1'b0);
    add_byte(8'hAA, 48'h2, 1'b0, 1'b0, 1'b0, 1'b0, '0, 16'd0, 1'b0);
    add_byte(8'hBB, 48'h40, 1'b1, 1'b0, 1'b0, 1'b0, '0, 16'd0, 1'b0);
    add_byte(8'hCC, 48'h41, 1'b0, 1'b0, 1'b0, 1'b0, '0, 16'd0, 1'b0);
    add_byte(8'hAA, 48'h42, 1'b0, 1'b0, 1'b0, 1'b0, '0, 16'd0, 1'b0);
    add_byte(8'h00, 48'h43, 1'b0, 1'b0, 1'b0, 1'b0, '0, 16'd0, 1'b0);
    add_byte(8'hCC, 48'h44, 1'b0, 1'b0, 1'b0, 1'b0, '0, 16'd0, 1'b0);
    add_byte(8'hCC, 48'h45, 1'b0, 1'b1, 1'b0, 1'b0, '0, 16'd0, 1'b0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        wait_drained();
        load_config(script[i].lo, script[i].hi, script[i].care, script[i].len,
                    script[i].lim);
      end else begin
        send_byte(script[i].item, script[i].fixed, script[i].fixed_hit,
                  script[i].fixed_out);
      end
    end

    for (int p = 0; p < 8; p++) begin
      calm = (p == 2 || p == 5);
      run_phase(42);
      if (p == 3) begin
        wait_drained();
        load_config({$urandom, $urandom}, {$urandom, $urandom}, 16'h0000, 5'd1, 16'hFFFF);
        calm = 1'b1;
        hold_req = 1'b1;
        for (int k = 0; k < 40; k++) begin
          it.data_byte = 8'($urandom);
          it.byte_address = 48'h0000_0100_0000 + k;
          it.region_start = (k == 0);
          it.new_scan = (k == 0);
          send_byte(it, 1'b0, 1'b0, '0);
        end
      end
    end

    wait_drained();
    $display("Scanned %0d bytes over %0d configurations; %0d matches checked, %0d mismatches",
             items_sent, cfg_loads, results_checked, err_count);
    $display("Input held off for %0d cycles while results were blocked", held_cycles);
    if (err_count == 0 && pending_matches.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
src/mbps_pkg.sv
src/mbps_front.sv
src/mbps_fifo.sv
src/mbps_back.sv
src/masked_byte_pattern_scan_core.sv
tb/tb_masked_byte_pattern_scan_core.sv
